// ----- sv/lerf_pkg.sv -----
// Package for the longest equal run finder.
// Holds field widths, reset constants and beat types shared by all files.
// No dependencies.
package lerf_pkg;

   localparam int MAX_ROWS_DEF   = 4096;
   localparam int VALUE_BITS_DEF = 16;

   localparam int ROW_VALUE_W = 16;
   localparam int ROW_W       = 12;
   localparam int LEN_W       = 13;
   localparam int MIN_RUN_W   = 12;

   localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST = 12'd8;
   localparam logic [LEN_W-1:0]     LEN_MAX     = 13'h1FFF;

   typedef logic [ROW_VALUE_W-1:0] row_value_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [LEN_W-1:0]       len_type;
   typedef logic [MIN_RUN_W-1:0]   min_run_type;

   typedef struct packed {
      row_value_type row_value;
      logic          last_row;
   } req_beat_type;

   typedef struct packed {
      row_value_type best_value;
      row_type       start_row;
      row_type       end_row;
   } rsp_beat_type;

endpackage

// ----- sv/lerf_ifs.sv -----
// Channel interfaces for the longest equal run finder: request, response, csr.
// Each carries valid, ready and the beat payload.
// Depends on lerf_pkg.
interface lerf_req_if;
   import lerf_pkg::*;
   logic          valid;
   logic          ready;
   row_value_type row_value;
   logic          last_row;
   modport source (output valid, output row_value, output last_row, input ready);
   modport sink   (input valid, input row_value, input last_row, output ready);
endinterface

interface lerf_rsp_if;
   import lerf_pkg::*;
   logic          valid;
   logic          ready;
   row_value_type best_value;
   row_type       start_row;
   row_type       end_row;
   modport source (output valid, output best_value, output start_row, output end_row,
                   input ready);
   modport sink   (input valid, input best_value, input start_row, input end_row,
                   output ready);
endinterface

interface lerf_csr_if;
   import lerf_pkg::*;
   logic        valid;
   logic        ready;
   min_run_type min_run;
   modport source (output valid, output min_run, input ready);
   modport sink   (input valid, input min_run, output ready);
endinterface

// ----- sv/lerf_in_reg.sv -----
// Input register of the longest equal run finder.
// Holds one request beat until the run core takes it.
// Depends on lerf_pkg.
module lerf_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  lerf_pkg::req_beat_type in_beat,
   output logic                  in_ready,
   output logic                  item_valid,
   output lerf_pkg::req_beat_type item,
   input  logic                  take
);
   import lerf_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff, beat_in;
   logic         load;

   assign in_ready   = !valid_ff || take;
   assign load       = in_valid && in_ready;
   assign item_valid = valid_ff;
   assign item       = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = in_beat;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule

// ----- sv/lerf_run_core.sv -----
// Run core of the longest equal run finder: open run, best run, row index
// and the response register. Depends on lerf_pkg.
module lerf_run_core #(
   parameter int MAX_ROWS   = lerf_pkg::MAX_ROWS_DEF,
   parameter int VALUE_BITS = lerf_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  lerf_pkg::req_beat_type item,
   output logic                   take,
   input  lerf_pkg::min_run_type  min_run,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lerf_pkg::rsp_beat_type rsp_beat
);
   import lerf_pkg::*;

   localparam int IDXW = $clog2(MAX_ROWS);
   localparam int VW   = (VALUE_BITS < ROW_VALUE_W) ? VALUE_BITS : ROW_VALUE_W;
   localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_ROWS - 1);

   logic [IDXW-1:0] idx_ff, idx_in;
   logic [VW-1:0]   cur_val_ff, cur_val_in;
   len_type         cur_len_ff, cur_len_in;
   logic [IDXW-1:0] cur_start_ff, cur_start_in;
   len_type         best_len_ff, best_len_in;
   logic [VW-1:0]   best_val_ff, best_val_in;
   logic [IDXW-1:0] best_start_ff, best_start_in;
   logic [IDXW-1:0] best_end_ff, best_end_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_beat_type    rsp_beat_ff, rsp_beat_in;

   logic [VW-1:0]   val;
   logic [IDXW-1:0] idx_prev, idx_next, start_next;
   logic            differ, close1, close2, report;
   len_type         b1_len, b2_len, run_len;
   logic [VW-1:0]   b1_val, b2_val, run_val;
   logic [IDXW-1:0] b1_start, b1_end, b2_start, b2_end, run_start;

   assign take      = item_valid && (!item.last_row || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_comb begin
      val        = item.row_value[VW-1:0];
      idx_prev   = (idx_ff == '0) ? IDX_LAST : idx_ff - 1'b1;
      idx_next   = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      start_next = (cur_start_ff == IDX_LAST) ? '0 : cur_start_ff + 1'b1;
      differ     = (val != cur_val_ff);

      // close the open run at the previous row when the value changes
      close1   = differ && (cur_val_ff != '0) && (cur_len_ff > best_len_ff);
      b1_len   = close1 ? cur_len_ff   : best_len_ff;
      b1_val   = close1 ? cur_val_ff   : best_val_ff;
      b1_start = close1 ? cur_start_ff : best_start_ff;
      b1_end   = close1 ? idx_prev     : best_end_ff;

      run_val   = cur_val_ff;
      run_len   = cur_len_ff;
      run_start = cur_start_ff;
      if (differ) begin
         run_val   = val;
         run_len   = (val != '0) ? len_type'(1) : '0;
         run_start = idx_ff;
      end else if (val != '0 && cur_len_ff != LEN_MAX) begin
         run_len = cur_len_ff + 1'b1;
      end else if (val != '0) begin
         // length saturated: slide start to keep end - start + 1 == length
         run_start = start_next;
      end

      // close the run still open on the final row
      close2   = (run_val != '0) && (run_len > b1_len);
      b2_len   = close2 ? run_len   : b1_len;
      b2_val   = close2 ? run_val   : b1_val;
      b2_start = close2 ? run_start : b1_start;
      b2_end   = close2 ? idx_ff    : b1_end;

      report = b2_len > {1'b0, min_run};
      rsp_beat_in.best_value = report ? ROW_VALUE_W'(b2_val) : '0;
      rsp_beat_in.start_row  = report ? ROW_W'(b2_start)     : '0;
      rsp_beat_in.end_row    = report ? ROW_W'(b2_end)       : '0;

      idx_in        = idx_ff;
      cur_val_in    = cur_val_ff;
      cur_len_in    = cur_len_ff;
      cur_start_in  = cur_start_ff;
      best_len_in   = best_len_ff;
      best_val_in   = best_val_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      if (take) begin
         if (item.last_row) begin
            idx_in        = '0;
            cur_val_in    = '0;
            cur_len_in    = '0;
            cur_start_in  = '0;
            best_len_in   = '0;
            best_val_in   = '0;
            best_start_in = '0;
            best_end_in   = '0;
         end else begin
            idx_in        = idx_next;
            cur_val_in    = run_val;
            cur_len_in    = run_len;
            cur_start_in  = run_start;
            best_len_in   = b1_len;
            best_val_in   = b1_val;
            best_start_in = b1_start;
            best_end_in   = b1_end;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && item.last_row) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cur_val_ff    <= '0;
         cur_len_ff    <= '0;
         cur_start_ff  <= '0;
         best_len_ff   <= '0;
         best_val_ff   <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         cur_val_ff    <= cur_val_in;
         cur_len_ff    <= cur_len_in;
         cur_start_ff  <= cur_start_in;
         best_len_ff   <= best_len_in;
         best_val_ff   <= best_val_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && item.last_row) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

endmodule

// ----- sv/longest_equal_run_finder.sv -----
// Top level of the longest equal run finder.
// Depends on lerf_pkg, lerf_ifs, lerf_in_reg and lerf_run_core.
//
// Takes one row value beat per cycle while no final beat waits on a stalled
// response, follows runs of equal nonzero values and on the beat marked
// last_row returns one response: value, first row and last row of the
// longest run (earliest on a tie) if its length exceeds min_run, else all
// zeros; frame state then clears. A request beat is held in the input
// register until the run core takes it, and the run core loads its response
// register when it takes the final beat. A pending response does not block
// non-final beats; the csr channel is always ready and min_run resets to 8.
module longest_equal_run_finder #(
   parameter int MAX_ROWS   = lerf_pkg::MAX_ROWS_DEF,
   parameter int VALUE_BITS = lerf_pkg::VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   lerf_req_if.sink   req,
   lerf_rsp_if.source rsp,
   lerf_csr_if.sink   csr
);
   import lerf_pkg::*;

   min_run_type  min_run_ff, min_run_in;
   req_beat_type in_beat, item;
   rsp_beat_type rsp_beat;
   logic         item_valid, take;

   assign csr.ready  = 1'b1;
   assign min_run_in = (csr.valid && csr.ready) ? csr.min_run : min_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MIN_RUN_RST;
      end else begin
         min_run_ff <= min_run_in;
      end
   end

   assign in_beat.row_value = req.row_value;
   assign in_beat.last_row  = req.last_row;

   lerf_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_beat    (in_beat),
      .in_ready   (req.ready),
      .item_valid (item_valid),
      .item       (item),
      .take       (take)
   );

   lerf_run_core #(
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) u_run_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .min_run    (min_run_ff),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_beat   (rsp_beat)
   );

   assign rsp.best_value = rsp_beat.best_value;
   assign rsp.start_row  = rsp_beat.start_row;
   assign rsp.end_row    = rsp_beat.end_row;

endmodule

// ----- sv/lerf_checker.sv -----
// Port checker for the longest equal run finder and its bind statement.
// Depends on lerf_pkg and longest_equal_run_finder.
module lerf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lerf_pkg::row_value_type best_value,
   input lerf_pkg::row_type       start_row,
   input lerf_pkg::row_type       end_row
);
   import lerf_pkg::*;

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_hold_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(best_value) && $stable(start_row) && $stable(end_row))
      else $error("response beat changed while stalled");

   a_no_run_zero_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && best_value == '0 |-> start_row == '0 && end_row == '0)
      else $error("rows reported without a run value");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind longest_equal_run_finder lerf_checker u_lerf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .best_value (rsp.best_value),
   .start_row  (rsp.start_row),
   .end_row    (rsp.end_row)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for longest_equal_run_finder: drives row beats and csr writes, predicts frame
// reports with a local run tracker or takes typed ones from the plan, and checks every
// response beat field by field. Depends on lerf_pkg, lerf_ifs and the RTL of the block.
module tb;
   import lerf_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ROWS  = 230;
   localparam int PLAN_LEN    = 20;

   typedef enum logic [1:0] {RUN_CHECKED, RUN_TYPED, SET_MIN_RUN} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      row_value_type value;
      int            reps;
      logic          last;
      rsp_beat_type  report;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lerf_req_if req_ch ();
   lerf_rsp_if rsp_ch ();
   lerf_csr_if csr_ch ();

   longest_equal_run_finder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5 clock = ~clock;

   min_run_type   trk_min_run;
   row_type       trk_row;
   row_value_type trk_value;
   len_type       trk_len;
   len_type       best_len;
   row_value_type best_value;
   row_type       best_start;
   row_type       best_end;

   rsp_beat_type  reports_due [$];
   row_value_type palette [4];
   int            fails        = 0;
   int            rows_sent    = 0;
   int            reports_seen = 0;
   int            idle_cycles  = 0;
   bit            idle_on      = 1'b1;
   bit            hold_rsp     = 1'b0;

   function automatic void clear_frame();
      trk_row    = '0;
      trk_value  = '0;
      trk_len    = '0;
      best_len   = '0;
      best_value = '0;
      best_start = '0;
      best_end   = '0;
   endfunction

   function automatic void close_open_run(row_type last_idx);
      if (trk_value != '0 && trk_len > best_len) begin
         best_len   = trk_len;
         best_value = trk_value;
         best_end   = last_idx;
         best_start = last_idx + row_type'(1) - row_type'(trk_len[ROW_W-1:0]);
      end
   endfunction

   function automatic bit track_row(input row_value_type v, input logic last,
                                    output rsp_beat_type rep);
      rep = '0;
      if (v != trk_value) begin
         close_open_run(trk_row - row_type'(1));
         trk_value = v;
         trk_len   = (v != '0) ? len_type'(1) : len_type'(0);
      end else if (v != '0 && trk_len < LEN_MAX) begin
         trk_len++;
      end
      if (!last) begin
         trk_row++;
         return 1'b0;
      end
      close_open_run(trk_row);
      if (best_len > len_type'(trk_min_run))
         rep = '{best_value, best_start, best_end};
      clear_frame();
      return 1'b1;
   endfunction

   task automatic send_row(input row_value_type v, input logic last, input bit use_typed,
                           input rsp_beat_type typed);
      rsp_beat_type rep;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.row_value <= v;
      req_ch.last_row  <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      rows_sent++;
      if (track_row(v, last, rep))
         reports_due.insert(reports_due.size(), use_typed ? typed : rep);
      @(negedge clock);
   endtask

   task automatic write_min_run(input min_run_type v);
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_ch.valid   <= 1'b1;
      csr_ch.min_run <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      trk_min_run = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_frame(output int rows);
      int            frame_len;
      int            run_len;
      row_value_type v;
      row_value_type prev;
      frame_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 48);
      rows = 0;
      prev = '0;
      while (rows < frame_len) begin
         run_len = $urandom_range(1, 14);
         case ($urandom_range(0, 9))
            0, 1: v = '0;
            2: v = prev;
            3: v = row_value_type'($urandom);
            default: v = palette[$urandom_range(0, 3)];
         endcase
         for (int r = 0; r < run_len && rows < frame_len; r++) begin
            send_row(($urandom_range(0, 30) == 0) ? row_value_type'($urandom) : v,
                     rows == frame_len - 1, 1'b0, '0);
            rows++;
         end
         prev = v;
      end
   endtask

   initial begin : receiver
      int idle_left;
      idle_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_left > 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left = $urandom_range(0, 3);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_reports
      rsp_beat_type due;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (reports_due.size() == 0) begin
            $error("response beat with no report due");
            fails++;
         end else begin
            due = reports_due.pop_front();
            reports_seen++;
            if (rsp_ch.best_value !== due.best_value) begin
               $error("best_value expected %h got %h", due.best_value, rsp_ch.best_value);
               fails++;
            end
            if (rsp_ch.start_row !== due.start_row) begin
               $error("start_row expected %0d got %0d", due.start_row, rsp_ch.start_row);
               fails++;
            end
            if (rsp_ch.end_row !== due.end_row) begin
               $error("end_row expected %0d got %0d", due.end_row, rsp_ch.end_row);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      plan_step_type plan [PLAN_LEN];
      min_run_type   phase_min;
      int            phase_rows;
      int            frame_rows;

      req_ch.valid     = 1'b0;
      req_ch.row_value = '0;
      req_ch.last_row  = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.min_run   = '0;
      trk_min_run      = MIN_RUN_RST;
      clear_frame();

      plan = '{
         '{RUN_TYPED,   16'hFFFF, 1,    1'b1, '{16'h0000, 12'd0, 12'd0}},
         '{RUN_CHECKED, 16'h0000, 5,    1'b0, '0},
         '{RUN_TYPED,   16'h0000, 1,    1'b1, '{16'h0000, 12'd0, 12'd0}},
         '{RUN_CHECKED, 16'h1234, 9,    1'b0, '0},
         '{RUN_TYPED,   16'h0000, 1,    1'b1, '{16'h1234, 12'd0, 12'd8}},
         '{RUN_TYPED,   16'h0005, 8,    1'b1, '{16'h0000, 12'd0, 12'd0}},
         '{RUN_TYPED,   16'h0007, 9,    1'b1, '{16'h0007, 12'd0, 12'd8}},
         '{RUN_CHECKED, 16'hAAAA, 10,   1'b0, '0},
         '{RUN_CHECKED, 16'h0000, 2,    1'b0, '0},
         '{RUN_TYPED,   16'h5555, 10,   1'b1, '{16'hAAAA, 12'd0, 12'd9}},
         '{RUN_CHECKED, 16'h0001, 10,   1'b0, '0},
         '{RUN_TYPED,   16'h0002, 11,   1'b1, '{16'h0002, 12'd10, 12'd20}},
         '{SET_MIN_RUN, 16'h0000, 0,    1'b0, '0},
         '{RUN_TYPED,   16'h0001, 1,    1'b1, '{16'h0001, 12'd0, 12'd0}},
         '{RUN_TYPED,   16'h0000, 1,    1'b1, '{16'h0000, 12'd0, 12'd0}},
         '{SET_MIN_RUN, 16'h0FFF, 0,    1'b0, '0},
         '{RUN_TYPED,   16'h0009, 40,   1'b1, '{16'h0000, 12'd0, 12'd0}},
         '{SET_MIN_RUN, 16'h0014, 0,    1'b0, '0},
         '{RUN_TYPED,   16'h0009, 21,   1'b1, '{16'h0009, 12'd0, 12'd20}},
         '{SET_MIN_RUN, 16'h0008, 0,    1'b0, '0}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         case (plan[i].kind)
            SET_MIN_RUN: begin
               write_min_run(plan[i].value[MIN_RUN_W-1:0]);
            end
            default: begin
               for (int r = 0; r < plan[i].reps; r++)
                  send_row(plan[i].value, plan[i].last && r == plan[i].reps - 1,
                           plan[i].kind == RUN_TYPED, plan[i].report);
            end
         endcase
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: phase_min = 12'd0;
            1: phase_min = 12'd3;
            2: phase_min = 12'd4095;
            3: phase_min = 12'd1;
            4: phase_min = min_run_type'($urandom_range(0, 12));
            default: phase_min = 12'd2;
         endcase
         write_min_run(phase_min);
         idle_on = (p != 5);
         foreach (palette[k]) palette[k] = row_value_type'($urandom);
         phase_rows = 0;
         while (phase_rows < PHASE_ROWS) begin
            send_random_frame(frame_rows);
            phase_rows += frame_rows;
         end
         if (p == 1) begin
            // stall the response side while single-row frames keep coming
            hold_rsp = 1'b1;
            repeat (60) send_row(row_value_type'($urandom), 1'b1, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d row beats and checked %0d frame reports", rows_sent, reports_seen);
      $display("over min_run settings from 0 to 4095, with ties, zero rows and long stalls.");
      if (fails == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
